### design/eepbc_pkg.sv
// Shared widths, bus command codes and memory command decode for the
// EEPROM page buffer controller. No dependencies.
package eepbc_pkg;

    localparam int unsigned CMD_W  = 3;
    localparam int unsigned ADDR_W = 8;
    localparam int unsigned DATA_W = 8;

    // Bus access codes
    localparam logic [CMD_W-1:0] CMD_READ_EE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_BUF    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE_CTRL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR_FLAGS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_CTRL   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_FLAGS  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ_STATUS = 3'd6;

    // Memory command field of the control byte
    localparam logic [2:0] MC_WRITE          = 3'd1;
    localparam logic [2:0] MC_ERASE          = 3'd2;
    localparam logic [2:0] MC_ERASE_WRITE    = 3'd3;
    localparam logic [2:0] MC_BUF_CLEAR      = 3'd4;
    localparam logic [2:0] MC_CHIP_ERASE     = 3'd5;
    localparam logic [2:0] MC_CHIP_ERASE_ALT = 3'd6;

    localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hff;
    localparam int unsigned       READY_BIT   = 0;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_COMMIT,
        OP_ERASE,
        OP_DROP,
        OP_ERASE_ALL
    } mem_op_t;

    // Map the low bits of a control byte onto a sweep operation
    function automatic mem_op_t decode_mem_op(input logic [2:0] code);
        mem_op_t op;
        unique case (code) inside
            MC_WRITE, MC_ERASE_WRITE:         op = OP_COMMIT;
            MC_ERASE:                         op = OP_ERASE;
            MC_BUF_CLEAR:                     op = OP_DROP;
            MC_CHIP_ERASE, MC_CHIP_ERASE_ALT: op = OP_ERASE_ALL;
            default:                          op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

### design/eepbc_in_if.sv
// Bus access channel of the EEPROM page buffer controller.
// Depends on eepbc_pkg for the field widths.
interface eepbc_in_if;
    import eepbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              ccp_open;

    modport source (output valid, command, address, write_data, ccp_open, input ready);
    modport sink   (input valid, command, address, write_data, ccp_open, output ready);
endinterface

### design/eepbc_out_if.sv
// Result channel of the EEPROM page buffer controller.
// Depends on eepbc_pkg for the field widths.
interface eepbc_out_if;
    import eepbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              command_done;
    logic              interrupt_request;

    modport source (output valid, read_data, command_done, interrupt_request, input ready);
    modport sink   (input valid, read_data, command_done, interrupt_request, output ready);
endinterface

### design/eeprom_page_buffer_controller.sv
// EEPROM page buffer controller: committed store, page buffer, dirty marks.
// Plain accesses go to the response state, which loads the result register once it is free;
// a memory command sweeps the arrays one entry a cycle through a shared index counter,
// then passes through the tail and response states. No access is accepted until a result is loaded.
// After reset the same counter erases the store and clears the dirty marks
// before the first access is accepted.
module eeprom_page_buffer_controller #(
    parameter int unsigned EEPROM_BYTES = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    eepbc_in_if.sink     in_ch,
    eepbc_out_if.source  out_ch,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data
);
    import eepbc_pkg::*;

    localparam int unsigned IDX_W = (EEPROM_BYTES > 1) ? $clog2(EEPROM_BYTES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EEPROM_BYTES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_TAIL,
        ST_RESP
    } state_t;

    // Arrays
    logic [DATA_W-1:0] ee_mem [EEPROM_BYTES];
    logic [DATA_W-1:0] bf_mem [EEPROM_BYTES];
    logic              dy_mem [EEPROM_BYTES];

    // Control and payload registers
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic              pend_reg, pend_next;
    mem_op_t           op_reg, op_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic              addr_ok_reg, addr_ok_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] ctrl_reg, ctrl_next;
    logic              ready_flag_reg, ready_flag_next;
    logic              irq_en_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_done_reg, out_done_next;
    logic              out_irq_reg, out_irq_next;

    // Registered read data of the arrays
    logic [DATA_W-1:0] ee_rd_reg;
    logic [DATA_W-1:0] bf_rd_reg;
    logic              dy_rd_reg;

    // Array port controls
    logic              ee_we, bf_we, dy_we;
    logic [IDX_W-1:0]  ee_waddr, dy_waddr;
    logic [DATA_W-1:0] ee_wdata;
    logic              dy_wdata;

    logic                  accept;
    logic                  addr_ok;
    logic [IDX_W+7:0]      addr_ext;
    logic [IDX_W-1:0]      in_idx;
    mem_op_t               in_op;
    logic [DATA_W-1:0]     resp_data;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign addr_ok     = (32'(in_ch.address) < 32'(EEPROM_BYTES));
    assign addr_ext    = (IDX_W + 8)'(in_ch.address);
    assign in_idx      = addr_ext[IDX_W-1:0];
    assign in_op       = decode_mem_op(in_ch.write_data[2:0]);

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.read_data         = out_data_reg;
    assign out_ch.command_done      = out_done_reg;
    assign out_ch.interrupt_request = out_irq_reg;

    // Pick the byte returned for the held access
    always_comb
    begin
        case (cmd_reg)
            CMD_READ_EE:    resp_data = addr_ok_reg ? ee_rd_reg : '0;
            CMD_READ_CTRL:  resp_data = ctrl_reg;
            CMD_READ_FLAGS: resp_data = DATA_W'(ready_flag_reg);
            default:        resp_data = '0;
        endcase
    end

    // Sequencer: clearing pass, access handling, sweep and result hand-off
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        wr_idx_next     = wr_idx_reg;
        pend_next       = pend_reg;
        op_next         = op_reg;
        cmd_next        = cmd_reg;
        addr_ok_next    = addr_ok_reg;
        done_next       = done_reg;
        ctrl_next       = ctrl_reg;
        ready_flag_next = ready_flag_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_done_next   = out_done_reg;
        out_irq_next    = out_irq_reg;

        ee_we    = 1'b0;
        ee_waddr = wr_idx_reg;
        ee_wdata = ERASED_BYTE;
        bf_we    = 1'b0;
        dy_we    = 1'b0;
        dy_waddr = wr_idx_reg;
        dy_wdata = 1'b0;

        // Drop a result once it is taken
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Write stage of the sweep: clear the mark, update the store per operation
        if (pend_reg)
        begin
            dy_we = 1'b1;
            case (op_reg)
                OP_COMMIT:
                begin
                    ee_we    = dy_rd_reg;
                    ee_wdata = bf_rd_reg;
                end
                OP_ERASE:     ee_we = dy_rd_reg;
                OP_ERASE_ALL: ee_we = 1'b1;
                default:      ee_we = 1'b0;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ee_we    = 1'b1;
                ee_waddr = idx_reg;
                dy_we    = 1'b1;
                dy_waddr = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = in_ch.command;
                    addr_ok_next = addr_ok;
                    done_next    = 1'b0;
                    idx_next     = '0;
                    state_next   = ST_RESP;
                    case (in_ch.command)
                        CMD_LOAD_BUF:
                        begin
                            bf_we    = addr_ok;
                            dy_we    = addr_ok;
                            dy_waddr = in_idx;
                            dy_wdata = 1'b1;
                        end
                        CMD_WRITE_CTRL:
                        begin
                            if (in_ch.ccp_open)
                            begin
                                ctrl_next = in_ch.write_data;
                                op_next   = in_op;
                                if (in_op != OP_NONE)
                                begin
                                    done_next       = 1'b1;
                                    ready_flag_next = 1'b1;
                                    state_next      = ST_SWEEP;
                                end
                            end
                        end
                        CMD_CLEAR_FLAGS:
                        begin
                            if (in_ch.write_data[READY_BIT])
                            begin
                                ready_flag_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                pend_next   = 1'b1;
                wr_idx_next = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TAIL:
            begin
                pend_next  = 1'b0;
                idx_next   = '0;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = resp_data;
                    out_done_next  = done_reg;
                    out_irq_next   = ready_flag_reg && irq_en_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            ctrl_reg       <= '0;
            ready_flag_reg <= 1'b0;
            irq_en_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            ctrl_reg       <= ctrl_next;
            ready_flag_reg <= ready_flag_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                irq_en_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wr_idx_reg   <= wr_idx_next;
        op_reg       <= op_next;
        cmd_reg      <= cmd_next;
        addr_ok_reg  <= addr_ok_next;
        done_reg     <= done_next;
        out_data_reg <= out_data_next;
        out_done_reg <= out_done_next;
        out_irq_reg  <= out_irq_next;
    end

    // Committed store: one write port, one read port captured on accept
    always_ff @(posedge clk)
    begin
        if (ee_we)
        begin
            ee_mem[ee_waddr] <= ee_wdata;
        end
        if (accept)
        begin
            ee_rd_reg <= ee_mem[in_idx];
        end
    end

    // Page buffer
    always_ff @(posedge clk)
    begin
        if (bf_we)
        begin
            bf_mem[in_idx] <= in_ch.write_data;
        end
        bf_rd_reg <= bf_mem[idx_reg];
    end

    // Dirty marks
    always_ff @(posedge clk)
    begin
        if (dy_we)
        begin
            dy_mem[dy_waddr] <= dy_wdata;
        end
        dy_rd_reg <= dy_mem[idx_reg];
    end

    // A new result only ever follows the response state
    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result loaded outside response state");

    // Sweep write stage lives only inside a sweep
    a_pend_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SWEEP || state_reg == ST_TAIL))
        else $error("sweep write outside sweep");

    // A finished memory command never returns data
    a_done_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_data_reg == '0)
        else $error("memory command returned data");

    // No access is taken during the clearing pass or a sweep
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_SWEEP) |-> !in_ch.ready)
        else $error("access accepted while busy");

endmodule

### dv/eeprom_page_buffer_controller_tb.sv
`timescale 1ns / 1ps
// Testbench for eeprom_page_buffer_controller: directed and random bus accesses, with every
// reply checked against an in-bench image of the store, page buffer, dirty marks and flags.
// Depends on eepbc_pkg, eepbc_in_if, eepbc_out_if and the controller RTL.
module eeprom_page_buffer_controller_tb;
    import eepbc_pkg::*;

    localparam int unsigned EE_BYTES        = 256;
    localparam int unsigned RANDOM_ACCESSES = 1750;
    localparam int unsigned PHASES          = 7;
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned SETTLE_CYCLES   = EE_BYTES + 8;
    localparam int unsigned MAX_REPORTS     = 50;

    // Bus code with no access behind it, and control codes that run nothing
    localparam logic [CMD_W-1:0] CMD_NOP     = 3'd7;
    localparam logic [2:0]       MC_NONE     = 3'd0;
    localparam logic [2:0]       MC_RESERVED = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              command_done;
        logic              interrupt_request;
    } access_reply_t;

    logic clk;
    logic rst_n       = 1'b0;
    logic cfg_wr_en   = 1'b0;
    logic cfg_wr_data = 1'b0;

    eepbc_in_if  in_ch ();
    eepbc_out_if out_ch ();

    eeprom_page_buffer_controller #(
        .EEPROM_BYTES (EE_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Image of the controller state as the accepted accesses leave it
    logic [DATA_W-1:0] ee_image    [EE_BYTES];
    logic [DATA_W-1:0] page_image  [EE_BYTES];
    logic              dirty_image [EE_BYTES];
    logic [DATA_W-1:0] ctrl_image;
    logic              ready_image;
    logic              irq_enable_image;

    access_reply_t awaited_replies [$];

    int unsigned n_errors;
    int unsigned n_accesses;
    int unsigned n_replies;
    int unsigned n_mem_cmds;
    int unsigned n_irq_seen;
    bit          no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Apply one access to the image and return the reply it should produce
    function automatic access_reply_t predict_access(
        input logic [CMD_W-1:0]  cmd,
        input logic [ADDR_W-1:0] addr,
        input logic [DATA_W-1:0] wdata,
        input logic              ccp
    );
        access_reply_t reply;
        logic          ran;
        int unsigned   idx;
        reply = '0;
        ran   = 1'b1;
        case (cmd)
            CMD_READ_EE:
            begin
                if (addr < EE_BYTES)
                    reply.read_data = ee_image[addr];
            end
            CMD_LOAD_BUF:
            begin
                if (addr < EE_BYTES)
                begin
                    page_image[addr]  = wdata;
                    dirty_image[addr] = 1'b1;
                end
            end
            CMD_WRITE_CTRL:
            begin
                if (ccp)
                begin
                    ctrl_image = wdata;
                    case (wdata[2:0])
                        MC_WRITE, MC_ERASE_WRITE:
                        begin
                            for (idx = 0; idx < EE_BYTES; idx++)
                                if (dirty_image[idx])
                                    ee_image[idx] = page_image[idx];
                        end
                        MC_ERASE:
                        begin
                            for (idx = 0; idx < EE_BYTES; idx++)
                                if (dirty_image[idx])
                                    ee_image[idx] = ERASED_BYTE;
                        end
                        MC_BUF_CLEAR:
                        begin
                        end
                        MC_CHIP_ERASE, MC_CHIP_ERASE_ALT:
                        begin
                            for (idx = 0; idx < EE_BYTES; idx++)
                                ee_image[idx] = ERASED_BYTE;
                        end
                        default:
                            ran = 1'b0;
                    endcase
                    // A command that runs drops the buffer and raises ready
                    if (ran)
                    begin
                        for (idx = 0; idx < EE_BYTES; idx++)
                            dirty_image[idx] = 1'b0;
                        ready_image = 1'b1;
                    end
                    reply.command_done = ran;
                end
            end
            CMD_CLEAR_FLAGS:
            begin
                if (wdata[READY_BIT])
                    ready_image = 1'b0;
            end
            CMD_READ_CTRL:
                reply.read_data = ctrl_image;
            CMD_READ_FLAGS:
                reply.read_data[READY_BIT] = ready_image;
            default:
            begin
            end
        endcase
        reply.interrupt_request = ready_image & irq_enable_image;
        return reply;
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_access(
        input logic [CMD_W-1:0]  cmd,
        input logic [ADDR_W-1:0] addr,
        input logic [DATA_W-1:0] wdata,
        input logic              ccp
    );
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.address    <= addr;
        in_ch.write_data <= wdata;
        in_ch.ccp_open   <= ccp;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        awaited_replies.push_back(predict_access(cmd, addr, wdata, ccp));
        n_accesses++;
    endtask

    // Drop valid and hold until every reply has come back
    task automatic drain_replies();
        in_ch.valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_irq_enable(input logic en);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(posedge clk);
        cfg_wr_en        <= 1'b0;
        irq_enable_image = en;
    endtask

    task automatic test_after_reset();
        send_access(CMD_READ_EE, 8'h00, 8'h00, 1'b0);
        send_access(CMD_READ_EE, 8'hff, 8'hff, 1'b1);
        send_access(CMD_READ_CTRL, 8'h00, 8'h00, 1'b0);
        send_access(CMD_READ_FLAGS, 8'h00, 8'h00, 1'b0);
        send_access(CMD_READ_STATUS, 8'h00, 8'h00, 1'b0);
        send_access(CMD_NOP, 8'hff, 8'hff, 1'b1);
        drain_replies();
    endtask

    // Fill the buffer at both address extremes, try a commit with the window
    // shut, then commit with it open and read the bytes back
    task automatic test_buffer_commit();
        send_access(CMD_LOAD_BUF, 8'h00, 8'h00, 1'b0);
        send_access(CMD_LOAD_BUF, 8'hff, 8'h5a, 1'b1);
        send_access(CMD_WRITE_CTRL, 8'h00, {5'b00000, MC_WRITE}, 1'b0);
        send_access(CMD_READ_EE, 8'hff, 8'h00, 1'b0);
        send_access(CMD_WRITE_CTRL, 8'hff, {5'b11111, MC_ERASE_WRITE}, 1'b1);
        send_access(CMD_READ_EE, 8'h00, 8'h00, 1'b0);
        send_access(CMD_READ_EE, 8'hff, 8'h00, 1'b0);
        send_access(CMD_READ_CTRL, 8'h00, 8'h00, 1'b0);
        drain_replies();
    endtask

    // Run every memory command code once except erase-and-write, upper control bits at random
    task automatic test_memory_commands();
        send_access(CMD_LOAD_BUF, 8'h40, 8'h12, 1'b0);
        send_access(CMD_WRITE_CTRL, 8'h00, {5'($urandom), MC_ERASE}, 1'b1);
        send_access(CMD_READ_EE, 8'h40, 8'h00, 1'b0);
        send_access(CMD_WRITE_CTRL, 8'h00, {5'($urandom), MC_NONE}, 1'b1);
        send_access(CMD_WRITE_CTRL, 8'h00, {5'($urandom), MC_RESERVED}, 1'b1);
        send_access(CMD_WRITE_CTRL, 8'h00, {5'($urandom), MC_BUF_CLEAR}, 1'b1);
        send_access(CMD_WRITE_CTRL, 8'h00, {5'($urandom), MC_CHIP_ERASE}, 1'b1);
        send_access(CMD_READ_EE, 8'h00, 8'h00, 1'b0);
        send_access(CMD_WRITE_CTRL, 8'h00, {5'($urandom), MC_CHIP_ERASE_ALT}, 1'b1);
        send_access(CMD_WRITE_CTRL, 8'h00, {5'($urandom), MC_WRITE}, 1'b1);
        drain_replies();
    endtask

    // With the interrupt enabled, check that only bit 0 clears the ready flag
    task automatic test_flags_and_irq();
        set_irq_enable(1'b1);
        send_access(CMD_CLEAR_FLAGS, 8'h00, 8'hfe, 1'b0);
        send_access(CMD_CLEAR_FLAGS, 8'h00, 8'h01, 1'b0);
        send_access(CMD_READ_FLAGS, 8'h00, 8'h00, 1'b0);
        drain_replies();
    endtask

    // Mostly page sequences (fill, command, read back, flags), some noise
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned stop;
        int unsigned base;
        int unsigned len;
        int unsigned i;
        logic [2:0]  code;
        for (phase = 0; phase < PHASES; phase++)
        begin
            set_irq_enable(phase[0] ^ (phase > 4));
            no_gaps = (phase == 3);
            stop    = n_accesses + RANDOM_ACCESSES / PHASES;
            while (n_accesses < stop)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    base = $urandom_range(0, EE_BYTES - 1);
                    len  = $urandom_range(1, 8);
                    for (i = 0; i < len; i++)
                        send_access(CMD_LOAD_BUF, ADDR_W'(base + i), DATA_W'($urandom),
                                    1'($urandom));
                    if ($urandom_range(0, 3) == 0)
                        send_access(CMD_READ_EE, ADDR_W'(base), DATA_W'($urandom), 1'($urandom));
                    code = 3'($urandom_range(MC_NONE, MC_RESERVED));
                    send_access(CMD_WRITE_CTRL, ADDR_W'($urandom), {5'($urandom), code},
                                $urandom_range(0, 7) != 0);
                    for (i = 0; i < len; i++)
                        send_access(CMD_READ_EE, ADDR_W'(base + i), DATA_W'($urandom),
                                    1'($urandom));
                    send_access(CMD_READ_FLAGS, ADDR_W'($urandom), DATA_W'($urandom),
                                1'($urandom));
                    if ($urandom_range(0, 1) == 0)
                        send_access(CMD_CLEAR_FLAGS, ADDR_W'($urandom), DATA_W'($urandom),
                                    1'($urandom));
                end
                else
                begin
                    send_access(CMD_W'($urandom_range(CMD_READ_EE, CMD_NOP)),
                                ADDR_W'($urandom), DATA_W'($urandom), 1'($urandom));
                end
            end
            drain_replies();
        end
        no_gaps = 1'b0;
    endtask

    // Take each reply after a random stall and compare it with the oldest awaited one
    initial
    begin : reply_checker
        access_reply_t want;
        int unsigned   stall;
        out_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            n_replies++;
            if (awaited_replies.size() == 0)
            begin
                report_mismatch($sformatf("reply %0d arrived with nothing awaited", n_replies));
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (out_ch.read_data !== want.read_data)
                    report_mismatch($sformatf("reply %0d: read_data %02h, expected %02h",
                                              n_replies, out_ch.read_data, want.read_data));
                if (out_ch.command_done !== want.command_done)
                    report_mismatch($sformatf("reply %0d: command_done %b, expected %b",
                                              n_replies, out_ch.command_done,
                                              want.command_done));
                if (out_ch.interrupt_request !== want.interrupt_request)
                    report_mismatch($sformatf("reply %0d: interrupt_request %b, expected %b",
                                              n_replies, out_ch.interrupt_request,
                                              want.interrupt_request));
                if (want.command_done)
                    n_mem_cmds++;
                if (want.interrupt_request)
                    n_irq_seen++;
            end
        end
    end

    // Count cycles with no word moving on either channel
    initial
    begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("[%0t] ERROR: no word accepted for %0d cycles", $realtime, STALL_LIMIT);
        $display("** eeprom_page_buffer_controller: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned idx;
        in_ch.valid      = 1'b0;
        in_ch.command    = CMD_READ_EE;
        in_ch.address    = '0;
        in_ch.write_data = '0;
        in_ch.ccp_open   = 1'b0;
        no_gaps          = 1'b0;
        // Image of the reset state: store erased, buffer empty
        for (idx = 0; idx < EE_BYTES; idx++)
        begin
            ee_image[idx]    = ERASED_BYTE;
            page_image[idx]  = '0;
            dirty_image[idx] = 1'b0;
        end
        ctrl_image       = '0;
        ready_image      = 1'b0;
        irq_enable_image = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        set_irq_enable(1'b0);

        test_after_reset();
        test_buffer_commit();
        test_memory_commands();
        test_flags_and_irq();
        test_random_traffic();

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_replies.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", awaited_replies.size()));

        $display("Run sent %0d accesses and checked %0d replies, %0d errors.",
                 n_accesses, n_replies, n_errors);
        $display("Replies included %0d memory commands run and %0d interrupt requests.",
                 n_mem_cmds, n_irq_seen);
        if (n_errors == 0)
            $display("** eeprom_page_buffer_controller: PASSED **");
        else
            $display("** eeprom_page_buffer_controller: FAILED **");
        $finish;
    end

endmodule

### eeprom_page_buffer_controller.f
design/eepbc_pkg.sv
design/eepbc_in_if.sv
design/eepbc_out_if.sv
design/eeprom_page_buffer_controller.sv
dv/eeprom_page_buffer_controller_tb.sv
